@@ src/command_frame_builder_assert.svh @@
// ----------------------------------------------------------------------------
// command_frame_builder_assert
// Assertion macros for the frame builder; only cfb_burst includes them. Each expects clk and
// rst to be in scope.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg
// Constants, types and the CRC-16 byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam logic [7:0]  FRAME_MARKER   = 8'h03;
  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd7;
  localparam int          BURST_MAX      = 8;
  localparam int          BURST_CNT_W    = $clog2(BURST_MAX + 1);

  // Request kinds carried on the action field
  localparam logic ACTION_HEADER = 1'b0;
  localparam logic ACTION_DATA   = 1'b1;

  // Bytes produced by one request, byte 0 leaves first
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_CNT_W-1:0]    count;
    logic                      ends_frame;
  } burst_t;

  // CRC-16/0x8005, data bits taken LSB first, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (data[i] != c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/cfb_engine.sv @@
// ----------------------------------------------------------------------------
// cfb_engine
// Frame state (running CRC, remaining data count, open flag) and the
// single-pass logic that turns one request into its burst of output bytes.
// ----------------------------------------------------------------------------
module cfb_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                action,
  input  logic [7:0]          opcode,
  input  logic [7:0]          first_param,
  input  logic [15:0]         second_param,
  input  logic [7:0]          payload_count,
  input  logic [7:0]          payload_byte,
  output cfb_pkg::burst_t     burst
);

  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  bytes_left;
  logic [7:0]  bytes_left_next;
  logic        frame_open;
  logic        frame_open_next;

  logic [7:0]  count_byte;
  logic [15:0] hdr_crc;
  logic [15:0] data_crc;
  logic [7:0]  left_dec;
  logic        data_last;

  // Header bytes and their CRC, unrolled over the five covered bytes
  always_comb begin
    count_byte = 8'(cfb_pkg::FRAME_OVERHEAD + payload_count);
    hdr_crc    = cfb_pkg::crc_feed(16'h0000, count_byte);
    hdr_crc    = cfb_pkg::crc_feed(hdr_crc, opcode);
    hdr_crc    = cfb_pkg::crc_feed(hdr_crc, first_param);
    hdr_crc    = cfb_pkg::crc_feed(hdr_crc, second_param[7:0]);
    hdr_crc    = cfb_pkg::crc_feed(hdr_crc, second_param[15:8]);
  end

  // Data byte update
  assign data_crc  = cfb_pkg::crc_feed(running_crc, payload_byte);
  assign left_dec  = bytes_left - 8'd1;
  assign data_last = (left_dec == 8'd0);

  // Build the burst and the next frame state
  always_comb begin
    burst            = '0;
    running_crc_next = running_crc;
    bytes_left_next  = bytes_left;
    frame_open_next  = frame_open;
    if (action == cfb_pkg::ACTION_HEADER) begin
      burst.bytes[0] = cfb_pkg::FRAME_MARKER;
      burst.bytes[1] = count_byte;
      burst.bytes[2] = opcode;
      burst.bytes[3] = first_param;
      burst.bytes[4] = second_param[7:0];
      burst.bytes[5] = second_param[15:8];
      burst.bytes[6] = hdr_crc[7:0];
      burst.bytes[7] = hdr_crc[15:8];
      if (payload_count == 8'd0) begin
        burst.count      = cfb_pkg::BURST_CNT_W'(8);
        burst.ends_frame = 1'b1;
      end else begin
        burst.count = cfb_pkg::BURST_CNT_W'(6);
      end
      running_crc_next = hdr_crc;
      bytes_left_next  = payload_count;
      frame_open_next  = (payload_count != 8'd0);
    end else if (frame_open) begin
      burst.bytes[0] = payload_byte;
      burst.bytes[1] = data_crc[7:0];
      burst.bytes[2] = data_crc[15:8];
      if (data_last) begin
        burst.count      = cfb_pkg::BURST_CNT_W'(3);
        burst.ends_frame = 1'b1;
      end else begin
        burst.count = cfb_pkg::BURST_CNT_W'(1);
      end
      running_crc_next = data_crc;
      bytes_left_next  = left_dec;
      frame_open_next  = !data_last;
    end
  end

  // Advance frame state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      bytes_left  <= '0;
      frame_open  <= 1'b0;
    end else if (take) begin
      running_crc <= running_crc_next;
      bytes_left  <= bytes_left_next;
      frame_open  <= frame_open_next;
    end
  end

endmodule

@@ src/cfb_burst.sv @@
// ----------------------------------------------------------------------------
// cfb_burst
// Output burst register: holds the bytes of one request and shifts them out
// one per handshake. Takes the next burst when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
`include "command_frame_builder_assert.svh"

module cfb_burst (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  cfb_pkg::burst_t burst,
  output logic            load_ready,
  output logic            frame_valid,
  input  logic            frame_ready,
  output logic [7:0]      frame_byte,
  output logic            frame_end
);

  logic [cfb_pkg::BURST_MAX-1:0][7:0] bytes;
  logic [cfb_pkg::BURST_CNT_W-1:0]    left;
  logic                               ends_frame;
  logic                               pop;
  logic                               last_one;

  assign last_one    = (left == cfb_pkg::BURST_CNT_W'(1));
  assign pop         = frame_valid && frame_ready;
  assign frame_valid = (left != '0);
  assign frame_byte  = bytes[0];
  assign frame_end   = last_one && ends_frame;
  assign load_ready  = !frame_valid || (last_one && frame_ready);

  // Count of bytes still to send
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= burst.count;
    end else if (pop) begin
      left <= left - cfb_pkg::BURST_CNT_W'(1);
    end
  end

  // Load or shift the byte store
  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= burst.bytes;
      ends_frame <= burst.ends_frame;
    end else if (pop) begin
      bytes <= bytes >> 8;
    end
  end

  `CFB_ASSERT_SAME(a_ready_only_near_empty, left > cfb_pkg::BURST_CNT_W'(1), !load_ready, "request accepted with bytes still queued")
  `CFB_ASSERT_SAME(a_end_on_last, frame_end, frame_valid && last_one, "frame end off the last byte")
  `CFB_ASSERT_NEXT(a_pop_counts_down, pop && !load && !last_one, left == $past(left) - cfb_pkg::BURST_CNT_W'(1), "byte count did not step down")
  `CFB_ASSERT_NEXT(a_load_shows, load && (burst.count != '0), frame_valid, "loaded burst not presented")

endmodule

@@ src/command_frame_builder.sv @@
// ----------------------------------------------------------------------------
// command_frame_builder
// Frames device commands: marker, count, opcode, params, data, CRC-16/0x8005.
//
//   channel  signals                         carries
//   request  req_valid / req_ready           header or one data byte
//   frame    frame_valid / frame_ready       one framed byte, end flag
//
// A request is taken in the cycle its bytes are built; its bytes leave one
// per cycle from the burst register while frame_ready is high, the first in
// the cycle after acceptance. A header gives 6 bytes (8 with zero length), a
// data byte 1 (3 for the last one); a data byte with no open frame gives
// nothing. A new request is taken when empty or as the last byte leaves.
// Reset empties the burst register and closes any frame; a stall on the frame
// side holds the current byte and back-pressures requests.
// ----------------------------------------------------------------------------
module command_frame_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        action,
  input  logic [7:0]  opcode,
  input  logic [7:0]  first_param,
  input  logic [15:0] second_param,
  input  logic [7:0]  payload_count,
  input  logic [7:0]  payload_byte,
  output logic        frame_valid,
  input  logic        frame_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  cfb_pkg::burst_t burst;
  logic            take;

  assign take = req_valid && req_ready;

  // Build the bytes for each request
  cfb_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .action        (action),
    .opcode        (opcode),
    .first_param   (first_param),
    .second_param  (second_param),
    .payload_count (payload_count),
    .payload_byte  (payload_byte),
    .burst         (burst)
  );

  // Hold and send them
  cfb_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .burst       (burst),
    .load_ready  (req_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

endmodule

@@ bench/frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the request and frame channels of the command frame builder. Every
// accepted request is turned into the framed bytes it should produce: marker,
// count, opcode, params, data and a CRC-16/0x8005 taken LSB first. Each byte
// that leaves the block is compared with the oldest one still due.
// ----------------------------------------------------------------------------
module frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic        action,
  input  logic [7:0]  opcode,
  input  logic [7:0]  first_param,
  input  logic [15:0] second_param,
  input  logic [7:0]  payload_count,
  input  logic [7:0]  payload_byte,
  input  logic        frame_valid,
  input  logic        frame_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } framed_byte_t;

  // Bytes still owed by the block, oldest first
  framed_byte_t frame_bytes_due[$];

  // Shadow of the framing state
  logic [15:0] crc_acc;
  logic [7:0]  data_left;
  logic        frame_active;

  // Shift one byte into the CRC, data bits LSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] acc_in,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    logic        fb;
    acc = acc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = data[i] ^ acc[15];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ cfb_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic queue_byte(input logic [7:0] value, input logic last);
    framed_byte_t b;
    b.value = value;
    b.last  = last;
    frame_bytes_due.push_back(b);
  endtask

  // Work out the bytes one accepted request should produce
  task automatic build_frame_bytes();
    logic [7:0] hdr [5];
    if (action == cfb_pkg::ACTION_HEADER) begin
      hdr[0] = 8'(cfb_pkg::FRAME_OVERHEAD + payload_count);
      hdr[1] = opcode;
      hdr[2] = first_param;
      hdr[3] = second_param[7:0];
      hdr[4] = second_param[15:8];
      queue_byte(cfb_pkg::FRAME_MARKER, 1'b0);
      crc_acc = '0;
      for (int k = 0; k < 5; k++) begin
        crc_acc = crc16_next(crc_acc, hdr[k]);
        queue_byte(hdr[k], 1'b0);
      end
      // Zero length: close the frame with its CRC straight away
      if (payload_count == 8'd0) begin
        queue_byte(crc_acc[7:0], 1'b0);
        queue_byte(crc_acc[15:8], 1'b1);
        data_left    = '0;
        frame_active = 1'b0;
      end else begin
        data_left    = payload_count;
        frame_active = 1'b1;
      end
    end else if (frame_active) begin
      crc_acc = crc16_next(crc_acc, payload_byte);
      queue_byte(payload_byte, 1'b0);
      data_left = data_left - 8'd1;
      if (data_left == 8'd0) begin
        queue_byte(crc_acc[7:0], 1'b0);
        queue_byte(crc_acc[15:8], 1'b1);
        frame_active = 1'b0;
      end
    end
    // A data byte with no open frame owes nothing
  endtask

  // Compare departing bytes, then predict from the accepted request
  always @(posedge clk) begin : check_and_predict
    framed_byte_t due;
    if (rst) begin
      frame_bytes_due.delete();
      crc_acc      = '0;
      data_left    = '0;
      frame_active = 1'b0;
      fail_count   = 0;
    end else begin
      if (frame_valid && frame_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte 0x%02h end %0b", $time, frame_byte,
                   frame_end);
          fail_count++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (frame_byte !== due.value) begin
            $display("%0t: frame_byte expected 0x%02h actual 0x%02h", $time,
                     due.value, frame_byte);
            fail_count++;
          end
          if (frame_end !== due.last) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, due.last,
                     frame_end);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        build_frame_bytes();
      end
    end
    pending = frame_bytes_due.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the command frame builder with directed frames, then random frames,
// broken frames and stray data bytes, with bursty requests and a stalling
// receiver. Checking is left to frame_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_REQUESTS = 90;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 20;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic        action;
  logic [7:0]  opcode;
  logic [7:0]  first_param;
  logic [15:0] second_param;
  logic [7:0]  payload_count;
  logic [7:0]  payload_byte;
  logic        frame_valid;
  logic        frame_ready;
  logic [7:0]  frame_byte;
  logic        frame_end;

  int fail_count;
  int pending;

  // Long receiver hold-offs asked for by the stimulus, and those carried out
  int hold_offs_asked;
  int hold_offs_done;
  int burst_left;

  command_frame_builder dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .action        (action),
    .opcode        (opcode),
    .first_param   (first_param),
    .second_param  (second_param),
    .payload_count (payload_count),
    .payload_byte  (payload_byte),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame_byte    (frame_byte),
    .frame_end     (frame_end)
  );

  frame_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .action        (action),
    .opcode        (opcode),
    .first_param   (first_param),
    .second_param  (second_param),
    .payload_count (payload_count),
    .payload_byte  (payload_byte),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame_byte    (frame_byte),
    .frame_end     (frame_end),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up well past the slowest legal run
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stall patterns, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    frame_ready     = 1'b0;
    hold_offs_done  = 0;
    mode            = 0;
    mode_left       = 0;
    forever begin
      @(negedge clk);
      if (hold_offs_done != hold_offs_asked) begin
        frame_ready <= 1'b0;
        hold_offs_done++;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        case (mode)
          0: frame_ready <= 1'b1;
          1: frame_ready <= ($urandom_range(0, 1) == 1);
          2: frame_ready <= ($urandom_range(0, 3) != 0);
          default: frame_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request and hold it until taken; entered and left at a falling edge
  task automatic push_request(input logic a, input logic [7:0] op,
                              input logic [7:0] p1, input logic [15:0] p2,
                              input logic [7:0] len, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_valid     <= 1'b1;
    action        <= a;
    opcode        <= op;
    first_param   <= p1;
    second_param  <= p2;
    payload_count <= len;
    payload_byte  <= b;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] op, input logic [7:0] p1,
                             input logic [15:0] p2, input logic [7:0] len);
    push_request(cfb_pkg::ACTION_HEADER, op, p1, p2, len, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] b);
    push_request(cfb_pkg::ACTION_DATA, 8'($urandom), 8'($urandom), 16'($urandom),
                 8'($urandom), b);
  endtask

  // Drop valid and wait until every owed byte has left
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int requests_done;
    int len;
    int sent;
    int pick;
    bit mid_pause_done;

    rst             = 1'b1;
    req_valid       = 1'b0;
    action          = cfb_pkg::ACTION_HEADER;
    opcode          = '0;
    first_param     = '0;
    second_param    = '0;
    payload_count   = '0;
    payload_byte    = '0;
    hold_offs_asked = 0;
    burst_left      = 0;
    requests_done   = 0;
    mid_pause_done  = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty frames at both field extremes
    send_header(8'h00, 8'h00, 16'h0000, 8'd0);
    send_header(8'hFF, 8'hFF, 16'hFFFF, 8'd0);
    // Stray data byte with no open frame
    send_data(8'hFF);
    // Short frames, data run to completion
    send_header(8'h01, 8'h02, 16'h1234, 8'd1);
    send_data(8'h00);
    send_header(8'hA5, 8'h5A, 16'h8001, 8'd2);
    send_data(8'hFF);
    send_data(8'h80);
    // New header drops a part-filled frame
    send_header(8'h10, 8'h20, 16'hBEEF, 8'd3);
    send_data(8'h11);
    // Lengths past 248 wrap the count byte
    send_header(8'h40, 8'h00, 16'h0000, 8'd255);
    send_data(8'h01);
    send_data(8'h02);
    send_header(8'h7F, 8'h80, 16'h7FFF, 8'd249);
    send_data(8'h55);
    send_header(8'h33, 8'h44, 16'h00FF, 8'd0);
    send_data(8'hAA);
    send_header(8'h80, 8'h01, 16'hFF00, 8'd128);
    send_data(8'h7F);
    send_header(8'h01, 8'h80, 16'h00FF, 8'd1);
    send_data(8'hC3);
    drain();

    // Random: mostly complete frames, some broken ones and stray bytes
    while (requests_done < RANDOM_REQUESTS) begin
      if (requests_done >= RANDOM_REQUESTS / 3 && hold_offs_asked == 0) begin
        hold_offs_asked++;
      end
      if (requests_done >= 2 * RANDOM_REQUESTS / 3 && !mid_pause_done) begin
        drain();
        mid_pause_done = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          len = $urandom_range(0, 3);
        end else if (pick < 85) begin
          len = $urandom_range(4, 12);
        end else begin
          len = $urandom_range(13, 40);
        end
        send_header(8'($urandom), 8'($urandom), 16'($urandom), 8'(len));
        for (int i = 0; i < len; i++) begin
          send_data(8'($urandom));
        end
        requests_done += len + 1;
      end else if (pick < 88) begin
        // Broken frame, left open for the next header to drop
        len  = $urandom_range(1, 255);
        sent = $urandom_range(0, (len - 1 < 6) ? len - 1 : 6);
        send_header(8'($urandom), 8'($urandom), 16'($urandom), 8'(len));
        for (int i = 0; i < sent; i++) begin
          send_data(8'($urandom));
        end
        requests_done += sent + 1;
      end else begin
        sent = $urandom_range(1, 3);
        for (int i = 0; i < sent; i++) begin
          send_data(8'($urandom));
          requests_done++;
        end
      end
    end

    // One full frame at the largest lengths
    len = $urandom_range(249, 255);
    send_header(8'($urandom), 8'($urandom), 16'($urandom), 8'(len));
    for (int i = 0; i < len; i++) begin
      send_data(8'($urandom));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
